[design/rc_pkg.sv]
// shared constants, types and microcode for the radix converter
package rc_pkg;

  // widths and sizes
  localparam int VALUE_BITS = 32;
  localparam int MAX_DIGITS = 32;
  localparam int BASE_W     = 6;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 6;
  localparam int REM_W      = DIGIT_W + 1;
  localparam int PROD_W     = VALUE_BITS + BASE_W;
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
  localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
  localparam int DIG_CNT_W  = DIG_IDX_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int STEP_W     = 3;

  // base limits and register reset values
  localparam logic [BASE_W-1:0] BASE_MIN       = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX       = BASE_W'(36);
  localparam logic [BASE_W-1:0] SRC_BASE_RESET = BASE_W'(10);
  localparam logic [BASE_W-1:0] TGT_BASE_RESET = BASE_W'(2);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BASE = 1'b1;

  // ascii codes
  localparam logic [CHAR_W-1:0] CH_0 = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9 = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_Z = 8'h5A;
  localparam logic [DIGIT_W-1:0] TEN = DIGIT_W'(10);

  // jump conditions of the sequencer
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_NOT_LAST,
    COND_BITS_LEFT,
    COND_MORE_DIV,
    COND_MORE_EMIT
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  // microcode steps
  localparam step_t STEP_WAIT     = 3'd0;
  localparam step_t STEP_MAC      = 3'd1;
  localparam step_t STEP_DIV_INIT = 3'd2;
  localparam step_t STEP_DIV      = 3'd3;
  localparam step_t STEP_STORE    = 3'd4;
  localparam step_t STEP_READ     = 3'd5;
  localparam step_t STEP_EMIT     = 3'd6;
  localparam step_t STEP_CLEAR    = 3'd7;

  // control word
  typedef struct packed {
    logic  busy;
    logic  mac;
    logic  div_init;
    logic  div_step;
    logic  store;
    logic  rd;
    logic  emit;
    logic  clear;
    cond_t cond;
    step_t target;
  } ctrl_t;

  // datapath status for the jump conditions
  typedef struct packed {
    logic last;
    logic bits_left;
    logic more_div;
    logic more_emit;
  } stat_t;

  // out-of-range bases saturate
  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    if (b < BASE_MIN) begin
      r = BASE_MIN;
    end else if (b > BASE_MAX) begin
      r = BASE_MAX;
    end else begin
      r = b;
    end
    return r;
  endfunction

  // returns {bad, value}; bad characters count as zero
  function automatic logic [DIGIT_W:0] char_value(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] t;
    logic [DIGIT_W:0]  r;
    t = '0;
    r = {1'b1, {DIGIT_W{1'b0}}};
    if (ch >= CH_0 && ch <= CH_9) begin
      t = ch - CH_0;
      r = {1'b0, t[DIGIT_W-1:0]};
    end else if (ch >= CH_A && ch <= CH_Z) begin
      t = ch - CH_A;
      r = {1'b0, t[DIGIT_W-1:0] + TEN};
    end
    return r;
  endfunction

  // digit value to '0'-'9','A'-'Z'
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] r;
    if (d < TEN) begin
      r = CH_0 + CHAR_W'(d);
    end else begin
      r = CH_A + CHAR_W'(d - TEN);
    end
    return r;
  endfunction

  // microcode rom
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t c;
    c = '0;
    case (step)
      STEP_WAIT: begin
        c.cond   = COND_NO_START;
        c.target = STEP_WAIT;
      end
      STEP_MAC: begin
        c.busy   = 1'b1;
        c.mac    = 1'b1;
        c.cond   = COND_NOT_LAST;
        c.target = STEP_WAIT;
      end
      STEP_DIV_INIT: begin
        c.busy     = 1'b1;
        c.div_init = 1'b1;
        c.cond     = COND_NEVER;
        c.target   = STEP_WAIT;
      end
      STEP_DIV: begin
        c.busy     = 1'b1;
        c.div_step = 1'b1;
        c.cond     = COND_BITS_LEFT;
        c.target   = STEP_DIV;
      end
      STEP_STORE: begin
        c.busy   = 1'b1;
        c.store  = 1'b1;
        c.cond   = COND_MORE_DIV;
        c.target = STEP_DIV_INIT;
      end
      STEP_READ: begin
        c.busy   = 1'b1;
        c.rd     = 1'b1;
        c.cond   = COND_NEVER;
        c.target = STEP_WAIT;
      end
      STEP_EMIT: begin
        c.busy   = 1'b1;
        c.emit   = 1'b1;
        c.cond   = COND_MORE_EMIT;
        c.target = STEP_READ;
      end
      STEP_CLEAR: begin
        c.busy   = 1'b1;
        c.clear  = 1'b1;
        c.cond   = COND_ALWAYS;
        c.target = STEP_WAIT;
      end
      default: begin
        c.cond   = COND_ALWAYS;
        c.target = STEP_WAIT;
      end
    endcase
    return c;
  endfunction

endpackage

[design/rc_sequencer.sv]
// microcode sequencer: step counter, control rom and conditional jumps
module rc_sequencer (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  rc_pkg::stat_t stat,
  output rc_pkg::ctrl_t ctrl
);

  rc_pkg::step_t pc;
  rc_pkg::step_t pc_next;
  logic          take;

  // control word of the current step
  assign ctrl = rc_pkg::ucode(pc);

  // jump condition select
  always_comb begin
    case (ctrl.cond)
      rc_pkg::COND_NEVER:     take = 1'b0;
      rc_pkg::COND_ALWAYS:    take = 1'b1;
      rc_pkg::COND_NO_START:  take = !start;
      rc_pkg::COND_NOT_LAST:  take = !stat.last;
      rc_pkg::COND_BITS_LEFT: take = stat.bits_left;
      rc_pkg::COND_MORE_DIV:  take = stat.more_div;
      rc_pkg::COND_MORE_EMIT: take = stat.more_emit;
      default:                take = 1'b0;
    endcase
  end

  assign pc_next = take ? ctrl.target : pc + 1'b1;

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= rc_pkg::STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

[design/rc_datapath.sv]
// datapath: base registers, multiply-add accumulator, bit-serial divider, digit store
module rc_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [rc_pkg::CHAR_W-1:0]      char_code,
  input  logic                           last_char,
  input  logic                           cfg_en,
  input  logic [rc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rc_pkg::BASE_W-1:0]      cfg_data,
  input  rc_pkg::ctrl_t                  ctrl,
  output rc_pkg::stat_t                  stat,
  output logic [rc_pkg::CHAR_W-1:0]      digit_char,
  output logic                           last_digit,
  output logic                           overflow,
  output logic                           bad_char
);

  logic [rc_pkg::BASE_W-1:0]     source_base;
  logic [rc_pkg::BASE_W-1:0]     target_base;
  logic [rc_pkg::CHAR_W-1:0]     char_reg;
  logic                          last_reg;
  logic [rc_pkg::VALUE_BITS-1:0] acc;
  logic                          overflow_seen;
  logic                          bad_seen;
  logic [rc_pkg::VALUE_BITS-1:0] quot;
  logic [rc_pkg::DIGIT_W-1:0]    rem;
  logic [rc_pkg::BIT_CNT_W-1:0]  bit_cnt;
  logic [rc_pkg::DIG_CNT_W-1:0]  ndig;
  logic [rc_pkg::DIGIT_W-1:0]    rd_digit;
  logic [rc_pkg::DIGIT_W-1:0]    digit_store [rc_pkg::MAX_DIGITS];

  logic [rc_pkg::BASE_W-1:0]     sb;
  logic [rc_pkg::BASE_W-1:0]     tb;
  logic [rc_pkg::DIGIT_W:0]      cv;
  logic [rc_pkg::PROD_W-1:0]     prod;
  logic [rc_pkg::REM_W-1:0]      trial;
  logic [rc_pkg::REM_W-1:0]      diff;
  logic                          geq;
  logic [rc_pkg::DIGIT_W-1:0]    rem_next;
  logic [rc_pkg::DIG_CNT_W-1:0]  ndig_m1;
  logic [rc_pkg::DIG_IDX_W-1:0]  wr_addr;
  logic [rc_pkg::DIG_IDX_W-1:0]  rd_addr;

  assign sb = rc_pkg::clamp_base(source_base);
  assign tb = rc_pkg::clamp_base(target_base);

  // multiply-add; any bit above the value width means wrap
  assign cv   = rc_pkg::char_value(char_reg);
  assign prod = rc_pkg::PROD_W'(acc) * rc_pkg::PROD_W'(sb)
              + rc_pkg::PROD_W'(cv[rc_pkg::DIGIT_W-1:0]);

  // one restoring division step
  assign trial    = {rem, quot[rc_pkg::VALUE_BITS-1]};
  assign geq      = trial >= rc_pkg::REM_W'(tb);
  assign diff     = trial - rc_pkg::REM_W'(tb);
  assign rem_next = geq ? diff[rc_pkg::DIGIT_W-1:0] : trial[rc_pkg::DIGIT_W-1:0];

  // digit store addressing
  assign ndig_m1 = ndig - 1'b1;
  assign wr_addr = ndig[rc_pkg::DIG_IDX_W-1:0];
  assign rd_addr = ndig_m1[rc_pkg::DIG_IDX_W-1:0];

  // status for the sequencer
  assign stat.last      = last_reg;
  assign stat.bits_left = bit_cnt != '0;
  assign stat.more_div  = (quot != '0)
                          && (ndig != rc_pkg::DIG_CNT_W'(rc_pkg::MAX_DIGITS - 1));
  assign stat.more_emit = ndig != rc_pkg::DIG_CNT_W'(1);

  // result fields
  assign digit_char = rc_pkg::digit_ascii(rd_digit);
  assign last_digit = ndig == rc_pkg::DIG_CNT_W'(1);
  assign overflow   = overflow_seen;
  assign bad_char   = bad_seen;

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      source_base   <= rc_pkg::SRC_BASE_RESET;
      target_base   <= rc_pkg::TGT_BASE_RESET;
      acc           <= '0;
      overflow_seen <= 1'b0;
      bad_seen      <= 1'b0;
      bit_cnt       <= '0;
      ndig          <= '0;
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          rc_pkg::CFG_SOURCE_BASE: source_base <= cfg_data;
          rc_pkg::CFG_TARGET_BASE: target_base <= cfg_data;
          default: ;
        endcase
      end
      if (ctrl.mac) begin
        acc <= prod[rc_pkg::VALUE_BITS-1:0];
        if (prod[rc_pkg::PROD_W-1:rc_pkg::VALUE_BITS] != '0) begin
          overflow_seen <= 1'b1;
        end
        if (cv[rc_pkg::DIGIT_W]) begin
          bad_seen <= 1'b1;
        end
      end
      if (ctrl.div_init) begin
        bit_cnt <= rc_pkg::BIT_CNT_W'(rc_pkg::VALUE_BITS - 1);
      end else if (ctrl.div_step) begin
        bit_cnt <= bit_cnt - 1'b1;
      end
      if (ctrl.store) begin
        ndig <= ndig + 1'b1;
      end else if (ctrl.emit) begin
        ndig <= ndig_m1;
      end
      if (ctrl.clear) begin
        acc           <= '0;
        overflow_seen <= 1'b0;
        bad_seen      <= 1'b0;
      end
    end
  end

  // input capture and divider payload
  always_ff @(posedge clk) begin
    if (accept) begin
      char_reg <= char_code;
      last_reg <= last_char;
    end
    if (ctrl.div_init) begin
      quot <= (ndig == '0) ? acc : quot;
      rem  <= '0;
    end else if (ctrl.div_step) begin
      quot <= {quot[rc_pkg::VALUE_BITS-2:0], geq};
      rem  <= rem_next;
    end
  end

  // digit store, registered read
  always_ff @(posedge clk) begin
    if (ctrl.store) begin
      digit_store[wr_addr] <= rem;
    end
    if (ctrl.rd) begin
      rd_digit <= digit_store[rd_addr];
    end
  end

endmodule

[design/radix_converter_top.sv]
// radix converter: digits in source base to ascii digits in target base
// a non-final character takes the accept step, then one multiply-add step
// the final character takes the accept step, one multiply-add step, then per output
// digit an init, a 32-step bit-serial divide and a store, then a read and an emit per
// emitted digit and a clear at the end; busy stays high from the multiply-add to the clear
// the receiver cannot stall; synchronous reset sets bases to 10 and 2, clears acc and flags
module radix_converter_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rc_pkg::CHAR_W-1:0]     char_code,
  input  logic                          last_char,
  input  logic                          cfg_en,
  input  logic [rc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc_pkg::BASE_W-1:0]     cfg_data,
  output logic                          valid,
  output logic [rc_pkg::CHAR_W-1:0]     digit_char,
  output logic                          last_digit,
  output logic                          overflow,
  output logic                          bad_char
);

  rc_pkg::ctrl_t ctrl;
  rc_pkg::stat_t stat;
  logic          accept;

  // input transaction
  assign accept = start && !busy;
  assign busy   = ctrl.busy;
  assign valid  = ctrl.emit;

  // sequencer
  rc_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // datapath
  rc_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .char_code  (char_code),
    .last_char  (last_char),
    .cfg_en     (cfg_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ctrl       (ctrl),
    .stat       (stat),
    .digit_char (digit_char),
    .last_digit (last_digit),
    .overflow   (overflow),
    .bad_char   (bad_char)
  );

  // results only come out while a number is in progress
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> busy) else $error("result strobe while idle");

  // an accepted character always starts a busy step
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("accepted character not processed");

  // the final digit ends the result stream
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (valid && last_digit) |=> !valid) else $error("result after final digit");

  // each digit but the last is followed by a read step without a digit, then the next digit
  a_digit_gap: assert property (@(posedge clk) disable iff (rst)
    (valid && !last_digit) |=> !valid ##1 valid) else $error("digit stream broken");

endmodule

[tb/radix_converter_top_tb.sv]
// self-checking testbench for the radix converter: directed and random numbers
`timescale 1ns / 1ps

module radix_converter_top_tb;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 64;
  localparam int PHASE_CHARS   = 100;

  // what the stimulus queue can hold
  typedef enum {
    JOB_CHAR,
    JOB_CFG,
    JOB_DRAIN,
    JOB_PHASE
  } job_kind_t;

  typedef struct {
    job_kind_t                    kind;
    logic [rc_pkg::CHAR_W-1:0]    code;
    logic                         fin;
    logic [rc_pkg::CFG_IDX_W-1:0] idx;
    logic [rc_pkg::BASE_W-1:0]    data;
    int                           pct;
  } job_t;

  // one expected output digit
  typedef struct packed {
    logic [rc_pkg::CHAR_W-1:0] ch;
    logic                      fin;
    logic                      ovf;
    logic                      bad;
  } digit_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  logic [rc_pkg::CHAR_W-1:0]    char_code = '0;
  logic                         last_char = 1'b0;
  logic                         cfg_en = 1'b0;
  logic [rc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rc_pkg::BASE_W-1:0]    cfg_data = '0;
  logic                         valid;
  logic [rc_pkg::CHAR_W-1:0]    digit_char;
  logic                         last_digit;
  logic                         overflow;
  logic                         bad_char;

  job_t   pending_jobs[$];
  digit_t digits_due[$];

  // predictor state
  logic [rc_pkg::BASE_W-1:0]     src_base = rc_pkg::SRC_BASE_RESET;
  logic [rc_pkg::BASE_W-1:0]     tgt_base = rc_pkg::TGT_BASE_RESET;
  logic [rc_pkg::VALUE_BITS-1:0] acc_value = '0;
  logic                          acc_ovf = 1'b0;
  logic                          acc_bad = 1'b0;

  // generator view of the source base
  logic [rc_pkg::BASE_W-1:0] gen_src = rc_pkg::SRC_BASE_RESET;

  logic xfer_done = 1'b0;
  int   idle_pct = 0;
  int   hold_cnt = 0;
  int   err_count = 0;
  int   cycle_count = 0;

  radix_converter_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .char_code  (char_code),
    .last_char  (last_char),
    .cfg_en     (cfg_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .valid      (valid),
    .digit_char (digit_char),
    .last_digit (last_digit),
    .overflow   (overflow),
    .bad_char   (bad_char)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // out-of-range bases saturate to 2 or 36
  function automatic int eff_base(input logic [rc_pkg::BASE_W-1:0] b);
    int r;
    r = int'(b);
    if (r < 2) begin
      r = 2;
    end else if (r > 36) begin
      r = 36;
    end
    return r;
  endfunction

  function automatic logic [rc_pkg::CHAR_W-1:0] ascii_of(input int d);
    logic [rc_pkg::CHAR_W-1:0] r;
    if (d < 10) begin
      r = rc_pkg::CH_0 + rc_pkg::CHAR_W'(d);
    end else begin
      r = rc_pkg::CH_A + rc_pkg::CHAR_W'(d - 10);
    end
    return r;
  endfunction

  // absorb one character; on the final one queue the converted digits
  task automatic convert_char(input logic [rc_pkg::CHAR_W-1:0] code, input logic fin);
    int                            src_eff;
    int                            tgt_eff;
    int                            dv;
    int                            n;
    int                            k;
    logic [63:0]                   sum;
    logic [rc_pkg::VALUE_BITS-1:0] v;
    int                            rems[rc_pkg::MAX_DIGITS];
    digit_t                        d;
    src_eff = eff_base(src_base);
    tgt_eff = eff_base(tgt_base);
    dv = 0;
    if (code >= rc_pkg::CH_0 && code <= rc_pkg::CH_9) begin
      dv = int'(code - rc_pkg::CH_0);
    end else if (code >= rc_pkg::CH_A && code <= rc_pkg::CH_Z) begin
      dv = int'(code - rc_pkg::CH_A) + 10;
    end else begin
      acc_bad = 1'b1;
    end
    sum = 64'(acc_value) * 64'(src_eff) + 64'(dv);
    if (sum[63:rc_pkg::VALUE_BITS] != '0) begin
      acc_ovf = 1'b1;
    end
    acc_value = sum[rc_pkg::VALUE_BITS-1:0];
    if (fin) begin
      v = acc_value;
      n = 0;
      do begin
        rems[n] = int'(v % rc_pkg::VALUE_BITS'(tgt_eff));
        n++;
        v = v / rc_pkg::VALUE_BITS'(tgt_eff);
      end while (v != 0 && n < rc_pkg::MAX_DIGITS);
      for (k = n - 1; k >= 0; k--) begin
        d.ch  = ascii_of(rems[k]);
        d.fin = (k == 0);
        d.ovf = acc_ovf;
        d.bad = acc_bad;
        digits_due.push_back(d);
      end
      acc_value = '0;
      acc_ovf = 1'b0;
      acc_bad = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // stimulus queue helpers
  task automatic add_char(input logic [rc_pkg::CHAR_W-1:0] code, input logic fin);
    job_t j;
    j = '{kind: JOB_CHAR, code: code, fin: fin, idx: '0, data: '0, pct: 0};
    pending_jobs.push_back(j);
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      add_char(s[i], i == s.len() - 1);
    end
  endtask

  // register write, only once the block has drained
  task automatic add_cfg(input logic [rc_pkg::CFG_IDX_W-1:0] idx,
                         input logic [rc_pkg::BASE_W-1:0] val);
    job_t j;
    j = '{kind: JOB_DRAIN, code: '0, fin: 1'b0, idx: '0, data: '0, pct: 0};
    pending_jobs.push_back(j);
    j = '{kind: JOB_CFG, code: '0, fin: 1'b0, idx: idx, data: val, pct: 0};
    pending_jobs.push_back(j);
    if (idx == rc_pkg::CFG_SOURCE_BASE) begin
      gen_src = val;
    end
  endtask

  task automatic add_phase(input int pct);
    job_t j;
    j = '{kind: JOB_PHASE, code: '0, fin: 1'b0, idx: '0, data: '0, pct: pct};
    pending_jobs.push_back(j);
  endtask

  function automatic logic [rc_pkg::BASE_W-1:0] pick_base();
    logic [rc_pkg::BASE_W-1:0] b;
    if ($urandom_range(9) == 0) begin
      b = rc_pkg::BASE_W'($urandom_range(63));
    end else begin
      b = rc_pkg::BASE_W'($urandom_range(36, 2));
    end
    return b;
  endfunction

  // mostly well-formed numbers, some all-zero, some raw noise
  task automatic add_random_number(output int len);
    int                        sb;
    int                        mode;
    int                        i;
    logic [rc_pkg::CHAR_W-1:0] c;
    sb = eff_base(gen_src);
    mode = int'($urandom_range(99));
    len = ($urandom_range(7) == 0) ? int'($urandom_range(34, 9))
                                   : int'($urandom_range(8, 1));
    for (i = 0; i < len; i++) begin
      if (mode < 80) begin
        c = ascii_of(int'($urandom_range(sb - 1)));
      end else if (mode < 88) begin
        c = rc_pkg::CH_0;
      end else begin
        c = rc_pkg::CHAR_W'($urandom_range(255));
      end
      add_char(c, i == len - 1);
    end
  endtask

  task automatic build_stimulus();
    int p;
    int count;
    int len;
    int pcts[3];
    pcts = '{20, 76, 0};
    add_phase(pcts[0]);
    // directed: reset bases 10 -> 2
    add_text("0");
    add_char(8'h00, 1'b0);
    add_char(8'hFF, 1'b0);
    add_char("a", 1'b0);
    add_char("7", 1'b1);
    add_text("Z9");
    // largest value, 32 output digits; base 0 acts as 2
    add_cfg(rc_pkg::CFG_SOURCE_BASE, 6'd16);
    add_cfg(rc_pkg::CFG_TARGET_BASE, 6'd0);
    add_text("FFFFFFFF");
    // base 63 acts as 36, overflow wraps
    add_cfg(rc_pkg::CFG_SOURCE_BASE, 6'd63);
    add_cfg(rc_pkg::CFG_TARGET_BASE, 6'd63);
    add_text("ZZZZZZZ");
    add_cfg(rc_pkg::CFG_SOURCE_BASE, 6'd0);
    add_cfg(rc_pkg::CFG_TARGET_BASE, 6'd36);
    add_text("1");
    add_cfg(rc_pkg::CFG_TARGET_BASE, 6'd1);
    add_text("101");
    // random numbers over three idle profiles
    for (p = 0; p < 3; p++) begin
      if (p != 0) begin
        add_phase(pcts[p]);
      end
      count = 0;
      while (count < PHASE_CHARS) begin
        if ($urandom_range(5) == 0) begin
          if ($urandom_range(1) == 0) begin
            add_cfg(rc_pkg::CFG_SOURCE_BASE, pick_base());
          end else begin
            add_cfg(rc_pkg::CFG_TARGET_BASE, pick_base());
          end
        end
        add_random_number(len);
        count += len;
      end
    end
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin : drive
    logic                         nx_start;
    logic                         nx_cfg;
    logic [rc_pkg::CHAR_W-1:0]    nx_code;
    logic                         nx_last;
    logic [rc_pkg::CFG_IDX_W-1:0] nx_idx;
    logic [rc_pkg::BASE_W-1:0]    nx_data;
    job_t                         j;
    nx_start = start;
    nx_cfg   = 1'b0;
    nx_code  = char_code;
    nx_last  = last_char;
    nx_idx   = cfg_index;
    nx_data  = cfg_data;
    if (rst) begin
      nx_start = 1'b0;
    end else if (!(start && !xfer_done)) begin
      nx_start = 1'b0;
      if (hold_cnt != 0) begin
        hold_cnt--;
      end else if (pending_jobs.size() != 0) begin
        j = pending_jobs[0];
        case (j.kind)
          JOB_PHASE: begin
            idle_pct = j.pct;
            void'(pending_jobs.pop_front());
          end
          JOB_DRAIN: begin
            if (digits_due.size() == 0 && !busy) begin
              hold_cnt = SETTLE_CYCLES;
              void'(pending_jobs.pop_front());
            end
          end
          JOB_CFG: begin
            nx_cfg  = 1'b1;
            nx_idx  = j.idx;
            nx_data = j.data;
            void'(pending_jobs.pop_front());
          end
          JOB_CHAR: begin
            if ($urandom_range(99) >= idle_pct) begin
              nx_start = 1'b1;
              nx_code  = j.code;
              nx_last  = j.fin;
              void'(pending_jobs.pop_front());
            end
          end
          default: begin
            void'(pending_jobs.pop_front());
          end
        endcase
      end
    end
    start     <= nx_start;
    cfg_en    <= nx_cfg;
    char_code <= nx_code;
    last_char <= nx_last;
    cfg_index <= nx_idx;
    cfg_data  <= nx_data;
  end

  // monitor: register writes, accepted transactions and results on the rising edge
  always @(posedge clk) begin : watch
    digit_t d;
    if (rst) begin
      xfer_done <= 1'b0;
      src_base  = rc_pkg::SRC_BASE_RESET;
      tgt_base  = rc_pkg::TGT_BASE_RESET;
      acc_value = '0;
      acc_ovf   = 1'b0;
      acc_bad   = 1'b0;
    end else begin
      if (cfg_en) begin
        if (cfg_index == rc_pkg::CFG_SOURCE_BASE) begin
          src_base = cfg_data;
        end else begin
          tgt_base = cfg_data;
        end
      end
      xfer_done <= start && !busy;
      if (start && !busy) begin
        convert_char(char_code, last_char);
      end
      if (valid) begin
        if (digits_due.size() == 0) begin
          report_mismatch("unexpected digit_char", int'(digit_char), 0);
        end else begin
          d = digits_due.pop_front();
          if (digit_char !== d.ch) begin
            report_mismatch("digit_char", int'(digit_char), int'(d.ch));
          end
          if (last_digit !== d.fin) begin
            report_mismatch("last_digit", int'(last_digit), int'(d.fin));
          end
          if (overflow !== d.ovf) begin
            report_mismatch("overflow", int'(overflow), int'(d.ovf));
          end
          if (bad_char !== d.bad) begin
            report_mismatch("bad_char", int'(bad_char), int'(d.bad));
          end
        end
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("radix_converter_top_tb NOT OK");
      $finish;
    end
  end

  // reset, run and final verdict
  initial begin
    build_stimulus();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (pending_jobs.size() != 0 || start || digits_due.size() != 0 || busy) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_count == 0 && digits_due.size() == 0) begin
      $display("radix_converter_top_tb OK");
    end else begin
      $display("radix_converter_top_tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
design/rc_pkg.sv
design/rc_sequencer.sv
design/rc_datapath.sv
design/radix_converter_top.sv
tb/radix_converter_top_tb.sv
